// ----- rtl/joystick_calibrate_scale_deadzone_defines.svh -----
// Assertion helpers for the joystick calibration block.
`ifndef JOYSTICK_CALIBRATE_SCALE_DEADZONE_DEFINES_SVH
`define JOYSTICK_CALIBRATE_SCALE_DEADZONE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JCSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/jcsd_pkg.sv -----
`default_nettype none
package jcsd_pkg;

	localparam int unsigned CAL_SAMPLES_DEF = 50;

	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned SUM_W    = 14;
	localparam int unsigned COUNT_W  = 6;
	localparam int unsigned CFG_W    = 7;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned DIV_W    = 15;
	localparam int unsigned DIR_W    = 3;

	localparam int unsigned SCALE_FULL = 100;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

	localparam logic [3:0] DIV_STEPS_SHORT = 4'd7;
	localparam logic [3:0] DIV_STEPS_FULL  = 4'd15;

	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_THRESH = 2'd2;

	localparam logic [CFG_W-1:0] DEADZONE_X_RST = 7'd15;
	localparam logic [CFG_W-1:0] DEADZONE_Y_RST = 7'd20;
	localparam logic [CFG_W-1:0] DIR_THRESH_RST = 7'd50;

	localparam logic [DIR_W-1:0] DIR_NEUTRAL = 3'd0;
	localparam logic [DIR_W-1:0] DIR_LEFT    = 3'd1;
	localparam logic [DIR_W-1:0] DIR_RIGHT   = 3'd2;
	localparam logic [DIR_W-1:0] DIR_DOWN    = 3'd3;
	localparam logic [DIR_W-1:0] DIR_UP      = 3'd4;

	typedef struct packed {
		logic             start;
		logic             short_mode;
		logic [DIV_W-1:0] dividend;
		logic [7:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             neg;
		logic             zero;
		logic [DIV_W-1:0] dividend;
		logic [7:0]       span;
	} scale_prep_t;

	// Offset magnitude times full scale, and the span on the side of the midpoint.
	function automatic scale_prep_t scale_prep(input logic [SAMPLE_W-1:0] smp,
		input logic [SAMPLE_W-1:0] mid);
		scale_prep_t p;
		logic [SAMPLE_W-1:0] mag;
		p.neg = (smp < mid);
		mag = p.neg ? (mid - smp) : (smp - mid);
		p.zero = (mag == '0);
		p.span = p.neg ? mid : (SAMPLE_MAX - mid);
		p.dividend = {7'b0, mag} * DIV_W'(SCALE_FULL);
		return p;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/jcsd_if.sv -----
`default_nettype none
interface jcsd_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] x_sample;
	logic [7:0] y_sample;
	logic       button_level;

	modport source (output valid, cmd, x_sample, y_sample, button_level, input ready);
	modport sink (input valid, cmd, x_sample, y_sample, button_level, output ready);
	modport mon (input valid, ready, cmd, x_sample, y_sample, button_level);
endinterface

interface jcsd_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] x_pos;
	logic signed [7:0] y_pos;
	logic [2:0]        direction;
	logic              btn_down;
	logic [7:0]        center_x;
	logic [7:0]        center_y;
	logic              calibration_done;

	modport source (output valid, x_pos, y_pos, direction, btn_down, center_x,
		center_y, calibration_done, input ready);
	modport sink (input valid, x_pos, y_pos, direction, btn_down, center_x,
		center_y, calibration_done, output ready);
	modport mon (input valid, ready, x_pos, y_pos, direction, btn_down, center_x,
		center_y, calibration_done);
endinterface

interface jcsd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [6:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport mon (input valid, ready, index, data);
endinterface
`default_nettype wire

// ----- rtl/jcsd_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle. In short mode the quotient is
// known to fit seven bits, so the upper dividend bits preload the remainder.
module jcsd_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire jcsd_pkg::div_req_t req,
	output jcsd_pkg::div_rsp_t     rsp
);
	logic [7:0]                   rem_q;
	logic [jcsd_pkg::DIV_W-1:0]   work_q;
	logic [7:0]                   dvs_q;
	logic [3:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [9:0]                   trial;
	logic                         ge;

	assign trial = {1'b0, rem_q, work_q[jcsd_pkg::DIV_W-1]} - {2'b0, dvs_q};
	assign ge = !trial[9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.short_mode ? jcsd_pkg::DIV_STEPS_SHORT
					: jcsd_pkg::DIV_STEPS_FULL;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			if (req.short_mode) begin
				rem_q  <= req.dividend[14:7];
				work_q <= {req.dividend[6:0], 8'b0};
			end else begin
				rem_q  <= '0;
				work_q <= req.dividend;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? trial[7:0] : {rem_q[6:0], work_q[jcsd_pkg::DIV_W-1]};
			work_q <= {work_q[jcsd_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = work_q;
endmodule
`default_nettype wire

// ----- rtl/joystick_calibrate_scale_deadzone.sv -----
// Joystick center calibration, scaling and deadzone.
// samples: one word per poll with cmd, raw X/Y readings and the button pin.
//   cmd 0 adds the readings to the calibration sums; after CAL_SAMPLES such
//   words the averages become the new midpoints. cmd 1 measures the stick.
// results: one word per input word with scaled X/Y (-100..100) after the
//   deadzones, the direction of the dominant axis, the button state, the
//   current midpoints and a flag for a finished calibration run.
// cfg: register writes (deadzone X, deadzone Y, direction threshold), always
//   ready; write only while no word is in flight.
// Path from accept to result valid: a calibration word goes straight to the
//   result state; a measurement and the word that ends a run pass through the
//   shared restoring divider, once per axis: 7 steps per axis for a
//   measurement, 15 steps per axis for the midpoint averages. One word is in
//   flight at a time; samples.ready rises again the cycle the result loads.
// Reset clears the sums, count and midpoints and loads the register defaults.
// A stalled receiver holds the result register; the block still accepts the
//   next word, but will not finish it until the result register drains.
`default_nettype none
module joystick_calibrate_scale_deadzone #(
	parameter int unsigned CAL_SAMPLES = jcsd_pkg::CAL_SAMPLES_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	jcsd_in_if.sink    samples,
	jcsd_out_if.source results,
	jcsd_cfg_if.sink   cfg
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_STX  = 3'd1;
	localparam logic [2:0] S_WTX  = 3'd2;
	localparam logic [2:0] S_WTY  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam logic [jcsd_pkg::COUNT_W-1:0] CAL_COUNT = jcsd_pkg::COUNT_W'(CAL_SAMPLES);

	logic [2:0] state_q;

	logic [jcsd_pkg::CFG_W-1:0] dz_x_q;
	logic [jcsd_pkg::CFG_W-1:0] dz_y_q;
	logic [jcsd_pkg::CFG_W-1:0] thr_q;

	logic [jcsd_pkg::SUM_W-1:0]    sum_x_q;
	logic [jcsd_pkg::SUM_W-1:0]    sum_y_q;
	logic [jcsd_pkg::COUNT_W-1:0]  count_q;
	logic [jcsd_pkg::SAMPLE_W-1:0] mid_x_q;
	logic [jcsd_pkg::SAMPLE_W-1:0] mid_y_q;

	logic                          cmd_q;
	logic                          cal_q;
	logic                          lvl_q;
	logic [jcsd_pkg::SAMPLE_W-1:0] xs_q;
	logic [jcsd_pkg::SAMPLE_W-1:0] ys_q;
	logic [6:0]                    xmag_q;
	logic [6:0]                    ymag_q;
	logic                          xneg_q;
	logic                          yneg_q;

	logic                          out_valid_q;
	logic signed [7:0]             x_pos_q;
	logic signed [7:0]             y_pos_q;
	logic [jcsd_pkg::DIR_W-1:0]    dir_q;
	logic                          btn_q;
	logic [7:0]                    cx_q;
	logic [7:0]                    cy_q;
	logic                          done_q;

	logic                          accept;
	logic                          out_free;
	logic [jcsd_pkg::COUNT_W-1:0]  count_next;
	jcsd_pkg::scale_prep_t         prep_x;
	jcsd_pkg::scale_prep_t         prep_y;
	jcsd_pkg::scale_prep_t         prep_sel;
	jcsd_pkg::div_req_t            div_req;
	jcsd_pkg::div_rsp_t            div_rsp;
	logic                          axis_y;
	logic [6:0]                    qmag;

	logic [6:0]                    ax;
	logic [6:0]                    ay;
	logic signed [7:0]             x_fin;
	logic signed [7:0]             y_fin;
	logic [jcsd_pkg::DIR_W-1:0]    dir_fin;

	assign samples.ready = (state_q == S_IDLE);
	assign accept = samples.valid && samples.ready;
	assign cfg.ready = 1'b1;
	assign out_free = !out_valid_q || results.ready;
	assign count_next = count_q + 1'b1;

	assign prep_x = jcsd_pkg::scale_prep(xs_q, mid_x_q);
	assign prep_y = jcsd_pkg::scale_prep(ys_q, mid_y_q);

	// The X division starts from its own state; Y starts as X completes.
	assign axis_y = (state_q == S_WTX);
	assign prep_sel = axis_y ? prep_y : prep_x;

	always_comb begin
		div_req.start = (state_q == S_STX) || ((state_q == S_WTX) && div_rsp.done);
		if (cal_q) begin
			div_req.short_mode = 1'b0;
			div_req.dividend   = {1'b0, axis_y ? sum_y_q : sum_x_q};
			div_req.divisor    = 8'(CAL_SAMPLES);
		end else begin
			div_req.short_mode = 1'b1;
			div_req.dividend   = prep_sel.dividend;
			div_req.divisor    = prep_sel.span;
		end
	end

	jcsd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign qmag = div_rsp.quotient[6:0];

	// Deadzone and dominant-axis decision; a tie in magnitude goes to Y.
	always_comb begin
		ax = (xmag_q < dz_x_q) ? 7'd0 : xmag_q;
		ay = (ymag_q < dz_y_q) ? 7'd0 : ymag_q;
		x_fin = xneg_q ? -$signed({1'b0, ax}) : $signed({1'b0, ax});
		y_fin = yneg_q ? -$signed({1'b0, ay}) : $signed({1'b0, ay});
		dir_fin = jcsd_pkg::DIR_NEUTRAL;
		if (ax > ay) begin
			if (ax > thr_q) begin
				dir_fin = xneg_q ? jcsd_pkg::DIR_LEFT : jcsd_pkg::DIR_RIGHT;
			end
		end else if (ay > thr_q) begin
			dir_fin = yneg_q ? jcsd_pkg::DIR_DOWN : jcsd_pkg::DIR_UP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dz_x_q      <= jcsd_pkg::DEADZONE_X_RST;
			dz_y_q      <= jcsd_pkg::DEADZONE_Y_RST;
			thr_q       <= jcsd_pkg::DIR_THRESH_RST;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			count_q     <= '0;
			mid_x_q     <= '0;
			mid_y_q     <= '0;
			cal_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					jcsd_pkg::REG_DEADZONE_X: dz_x_q <= cfg.data;
					jcsd_pkg::REG_DEADZONE_Y: dz_y_q <= cfg.data;
					jcsd_pkg::REG_DIR_THRESH: thr_q  <= cfg.data;
					default: ;
				endcase
			end

			// A new word may load in the same cycle the old one drains.
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (samples.cmd) begin
							cal_q   <= 1'b0;
							state_q <= S_STX;
						end else begin
							sum_x_q <= sum_x_q + {6'b0, samples.x_sample};
							sum_y_q <= sum_y_q + {6'b0, samples.y_sample};
							if (count_next == CAL_COUNT) begin
								count_q <= '0;
								cal_q   <= 1'b1;
								state_q <= S_STX;
							end else begin
								count_q <= count_next;
								cal_q   <= 1'b0;
								state_q <= S_FIN;
							end
						end
					end
				end
				S_STX: begin
					state_q <= S_WTX;
				end
				S_WTX: begin
					if (div_rsp.done) begin
						if (cal_q) begin
							mid_x_q <= div_rsp.quotient[7:0];
						end
						state_q <= S_WTY;
					end
				end
				S_WTY: begin
					if (div_rsp.done) begin
						if (cal_q) begin
							mid_y_q <= div_rsp.quotient[7:0];
							sum_x_q <= '0;
							sum_y_q <= '0;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= samples.cmd;
			xs_q  <= samples.x_sample;
			ys_q  <= samples.y_sample;
			lvl_q <= samples.button_level;
		end
		// A zero offset reads zero; this also covers the zero-span case.
		if ((state_q == S_WTX) && div_rsp.done) begin
			xneg_q <= prep_x.neg;
			xmag_q <= prep_x.zero ? 7'd0 : qmag;
		end
		if ((state_q == S_WTY) && div_rsp.done) begin
			yneg_q <= prep_y.neg;
			ymag_q <= prep_y.zero ? 7'd0 : qmag;
		end
		if ((state_q == S_FIN) && out_free) begin
			x_pos_q <= cmd_q ? x_fin : 8'sd0;
			y_pos_q <= cmd_q ? y_fin : 8'sd0;
			dir_q   <= cmd_q ? dir_fin : jcsd_pkg::DIR_NEUTRAL;
			btn_q   <= !lvl_q;
			cx_q    <= mid_x_q;
			cy_q    <= mid_y_q;
			done_q  <= cal_q;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.x_pos            = x_pos_q;
	assign results.y_pos            = y_pos_q;
	assign results.direction        = dir_q;
	assign results.btn_down         = btn_q;
	assign results.center_x         = cx_q;
	assign results.center_y         = cy_q;
	assign results.calibration_done = done_q;
endmodule
`default_nettype wire

// ----- rtl/jcsd_checker.sv -----
`default_nettype none
`include "joystick_calibrate_scale_deadzone_defines.svh"
module jcsd_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic signed [7:0]          x_pos,
	input wire logic signed [7:0]          y_pos,
	input wire logic [jcsd_pkg::DIR_W-1:0] direction,
	input wire logic                       calibration_done
);
	// One word in flight: ready drops after an accepted word.
	`JCSD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready stayed high after an accepted word")
	`JCSD_ASSERT_NOW(a_x_range, clk, arst_n, out_valid, (x_pos >= -8'sd100) && (x_pos <= 8'sd100), "x_pos outside the scaled range")
	`JCSD_ASSERT_NOW(a_cal_zero, clk, arst_n, out_valid && calibration_done, (x_pos == 8'sd0) && (y_pos == 8'sd0) && (direction == jcsd_pkg::DIR_NEUTRAL), "calibration word reported a position")
	`JCSD_ASSERT_NOW(a_dir_sign, clk, arst_n, out_valid && ((direction == jcsd_pkg::DIR_LEFT) || (direction == jcsd_pkg::DIR_DOWN)), (x_pos < 8'sd0) || (y_pos < 8'sd0), "negative direction without a negative axis")
	`JCSD_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(x_pos) && $stable(direction), "stalled result changed")
endmodule

bind joystick_calibrate_scale_deadzone jcsd_checker u_jcsd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (samples.valid),
	.in_ready         (samples.ready),
	.out_valid        (results.valid),
	.out_ready        (results.ready),
	.x_pos            (results.x_pos),
	.y_pos            (results.y_pos),
	.direction        (results.direction),
	.calibration_done (results.calibration_done)
);
`default_nettype wire
